>>> hw/rtl/aabb_overlap_min_penetration_side_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box overlap block
// Concurrent checks that are active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_MIN_PENETRATION_SIDE_DEFINES_SVH
`define AABB_OVERLAP_MIN_PENETRATION_SIDE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every rising edge outside of reset.
`define AOMPS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box overlap check failed");
// Plain condition checked at every rising edge outside of reset.
`define AOMPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("box overlap invariant failed");
`else
`define AOMPS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define AOMPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/aomps_pkg.sv
// ----------------------------------------------------------------------------
// Box overlap package
// Shared widths, side codes and the flag bundle between pipeline stages.
// ----------------------------------------------------------------------------
package aomps_pkg;

    // Field widths.
    localparam int POS_W   = 24;
    localparam int SIZE_W  = 24;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = SIZE_W + SCALE_W;
    // size * scale is Q.24, halving and returning to Q.12 drops 13 bits.
    localparam int HALF_SHIFT = 13;
    localparam int HALF_W  = PROD_W - HALF_SHIFT;
    // Box bounds, signed.
    localparam int BND_W   = HALF_W + 2;
    // Penetration differences, signed, and their magnitudes.
    localparam int VAL_W   = 31;
    localparam int MAG_W   = VAL_W - 1;

    typedef logic [HALF_W-1:0]        t_half;
    typedef logic signed [BND_W-1:0]  t_bnd;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic [MAG_W-1:0]         t_mag;

    // Side codes of the result.
    typedef enum logic [2:0] {
        FACE_NONE   = 3'd0,
        FACE_RIGHT  = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_BOTTOM = 3'd3,
        FACE_TOP    = 3'd4
    } t_side;

    // Candidate indexes in priority order.
    localparam int CAND_RIGHT  = 0;
    localparam int CAND_LEFT   = 1;
    localparam int CAND_BOTTOM = 2;
    localparam int CAND_TOP    = 3;
    localparam int NUM_CAND    = 4;

    // Overlap flag and per-candidate qualification.
    typedef struct packed {
        logic                hit;
        logic [NUM_CAND-1:0] qual;
    } t_cand_flags;

endpackage

>>> hw/rtl/aomps_half_ext.sv
// ----------------------------------------------------------------------------
// Half extent multiplier
// Registers (size * scale) >> 13 for one box axis.
// ----------------------------------------------------------------------------
module aomps_half_ext (
    input  logic                            i_clk,
    input  logic [aomps_pkg::SIZE_W-1:0]    i_size,
    input  logic [aomps_pkg::SCALE_W-1:0]   i_scale,
    output aomps_pkg::t_half                o_half
);

    logic [aomps_pkg::PROD_W-1:0] prod;
    aomps_pkg::t_half             r_half;
    aomps_pkg::t_half             n_half;

    // Unsigned product, truncated to Q.12 after the halving.
    always_comb begin
        prod   = aomps_pkg::PROD_W'(i_size) * aomps_pkg::PROD_W'(i_scale);
        n_half = prod[aomps_pkg::PROD_W-1:aomps_pkg::HALF_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        r_half <= n_half;
    end

    assign o_half = r_half;

endmodule

>>> hw/rtl/aomps_cand.sv
// ----------------------------------------------------------------------------
// Bounds and penetration candidates
// Stage two forms the box bounds; stage three forms the four differences,
// their magnitudes, the overlap flag and the qualification of each candidate.
// ----------------------------------------------------------------------------
module aomps_cand (
    input  logic                                          i_clk,
    input  logic signed [aomps_pkg::POS_W-1:0]            i_a_pos_x,
    input  logic signed [aomps_pkg::POS_W-1:0]            i_a_pos_y,
    input  aomps_pkg::t_half                              i_a_half_x,
    input  aomps_pkg::t_half                              i_a_half_y,
    input  logic signed [aomps_pkg::POS_W-1:0]            i_b_pos_x,
    input  logic signed [aomps_pkg::POS_W-1:0]            i_b_pos_y,
    input  aomps_pkg::t_half                              i_b_half_x,
    input  aomps_pkg::t_half                              i_b_half_y,
    input  logic [aomps_pkg::SIZE_W-1:0]                  i_b_size_x,
    input  logic [aomps_pkg::SIZE_W-1:0]                  i_b_size_y,
    output aomps_pkg::t_cand_flags                        o_flags,
    output aomps_pkg::t_mag [aomps_pkg::NUM_CAND-1:0]     o_mag,
    output aomps_pkg::t_val [aomps_pkg::NUM_CAND-1:0]     o_val
);

    // Stage two registers.
    aomps_pkg::t_bnd                 r_a_min_x, r_a_max_x, r_a_min_y, r_a_max_y;
    aomps_pkg::t_bnd                 r_b_min_x, r_b_max_x, r_b_min_y, r_b_max_y;
    logic [aomps_pkg::SIZE_W-1:0]    r_b_size_x, r_b_size_y;

    // Stage three registers.
    aomps_pkg::t_cand_flags                        r_flags, n_flags;
    aomps_pkg::t_mag [aomps_pkg::NUM_CAND-1:0]     r_mag, n_mag;
    aomps_pkg::t_val [aomps_pkg::NUM_CAND-1:0]     r_val, n_val;
    logic [aomps_pkg::NUM_CAND-1:0]                cand_neg;
    logic [aomps_pkg::NUM_CAND-1:0]                cand_pos;
    aomps_pkg::t_mag [aomps_pkg::NUM_CAND-1:0]     cand_lim;

    // Bounds: centre minus and plus the half extent.
    always_ff @(posedge i_clk) begin
        r_a_min_x  <= aomps_pkg::BND_W'(i_a_pos_x) - $signed({2'b00, i_a_half_x});
        r_a_max_x  <= aomps_pkg::BND_W'(i_a_pos_x) + $signed({2'b00, i_a_half_x});
        r_a_min_y  <= aomps_pkg::BND_W'(i_a_pos_y) - $signed({2'b00, i_a_half_y});
        r_a_max_y  <= aomps_pkg::BND_W'(i_a_pos_y) + $signed({2'b00, i_a_half_y});
        r_b_min_x  <= aomps_pkg::BND_W'(i_b_pos_x) - $signed({2'b00, i_b_half_x});
        r_b_max_x  <= aomps_pkg::BND_W'(i_b_pos_x) + $signed({2'b00, i_b_half_x});
        r_b_min_y  <= aomps_pkg::BND_W'(i_b_pos_y) - $signed({2'b00, i_b_half_y});
        r_b_max_y  <= aomps_pkg::BND_W'(i_b_pos_y) + $signed({2'b00, i_b_half_y});
        r_b_size_x <= i_b_size_x;
        r_b_size_y <= i_b_size_y;
    end

    // Differences, magnitudes and qualification. The overlap test is the
    // sign pattern of the same four differences.
    always_comb begin
        n_val[aomps_pkg::CAND_RIGHT]  = aomps_pkg::VAL_W'(r_b_min_x)
                                      - aomps_pkg::VAL_W'(r_a_max_x);
        n_val[aomps_pkg::CAND_LEFT]   = aomps_pkg::VAL_W'(r_b_max_x)
                                      - aomps_pkg::VAL_W'(r_a_min_x);
        n_val[aomps_pkg::CAND_BOTTOM] = aomps_pkg::VAL_W'(r_b_min_y)
                                      - aomps_pkg::VAL_W'(r_a_max_y);
        n_val[aomps_pkg::CAND_TOP]    = aomps_pkg::VAL_W'(r_b_max_y)
                                      - aomps_pkg::VAL_W'(r_a_min_y);
        cand_lim[aomps_pkg::CAND_RIGHT]  = aomps_pkg::MAG_W'(r_b_size_x);
        cand_lim[aomps_pkg::CAND_LEFT]   = aomps_pkg::MAG_W'(r_b_size_x);
        cand_lim[aomps_pkg::CAND_BOTTOM] = aomps_pkg::MAG_W'(r_b_size_y);
        cand_lim[aomps_pkg::CAND_TOP]    = aomps_pkg::MAG_W'(r_b_size_y);
        for (int i = 0; i < aomps_pkg::NUM_CAND; i++) begin
            cand_neg[i] = n_val[i][aomps_pkg::VAL_W-1];
            cand_pos[i] = !cand_neg[i] && (n_val[i] != '0);
            n_mag[i]    = cand_neg[i] ? aomps_pkg::MAG_W'(-n_val[i])
                                      : aomps_pkg::MAG_W'(n_val[i]);
        end
        // Right and bottom need a value at or below zero, left and top at or above.
        n_flags.qual[aomps_pkg::CAND_RIGHT]  = !cand_pos[aomps_pkg::CAND_RIGHT]
            && (n_mag[aomps_pkg::CAND_RIGHT] < cand_lim[aomps_pkg::CAND_RIGHT]);
        n_flags.qual[aomps_pkg::CAND_LEFT]   = !cand_neg[aomps_pkg::CAND_LEFT]
            && (n_mag[aomps_pkg::CAND_LEFT] < cand_lim[aomps_pkg::CAND_LEFT]);
        n_flags.qual[aomps_pkg::CAND_BOTTOM] = !cand_pos[aomps_pkg::CAND_BOTTOM]
            && (n_mag[aomps_pkg::CAND_BOTTOM] < cand_lim[aomps_pkg::CAND_BOTTOM]);
        n_flags.qual[aomps_pkg::CAND_TOP]    = !cand_neg[aomps_pkg::CAND_TOP]
            && (n_mag[aomps_pkg::CAND_TOP] < cand_lim[aomps_pkg::CAND_TOP]);
        n_flags.hit = !cand_pos[aomps_pkg::CAND_RIGHT] && !cand_neg[aomps_pkg::CAND_LEFT]
                   && !cand_pos[aomps_pkg::CAND_BOTTOM] && !cand_neg[aomps_pkg::CAND_TOP];
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_mag   <= n_mag;
        r_val   <= n_val;
    end

    assign o_flags = r_flags;
    assign o_mag   = r_mag;
    assign o_val   = r_val;

endmodule

>>> hw/rtl/aomps_select.sv
// ----------------------------------------------------------------------------
// Minimum penetration select
// Picks the smallest qualifying candidate, earlier one on ties, and
// registers the result item.
// ----------------------------------------------------------------------------
module aomps_select (
    input  logic                                          i_clk,
    input  aomps_pkg::t_cand_flags                        i_flags,
    input  aomps_pkg::t_mag [aomps_pkg::NUM_CAND-1:0]     i_mag,
    input  aomps_pkg::t_val [aomps_pkg::NUM_CAND-1:0]     i_val,
    output logic                                          o_hit,
    output aomps_pkg::t_side                              o_side,
    output aomps_pkg::t_val                               o_offset_x,
    output aomps_pkg::t_val                               o_offset_y
);

    logic             take_1, take_3, take_hi;
    logic             any_lo, any_hi;
    aomps_pkg::t_mag  mag_lo, mag_hi;
    logic [1:0]       win_idx;

    logic             r_hit, n_hit;
    aomps_pkg::t_side r_side, n_side;
    aomps_pkg::t_val  r_offset_x, n_offset_x;
    aomps_pkg::t_val  r_offset_y, n_offset_y;

    // Two-level tree; the later entry wins only when strictly smaller.
    always_comb begin
        take_1  = i_flags.qual[aomps_pkg::CAND_LEFT]
               && (!i_flags.qual[aomps_pkg::CAND_RIGHT]
                   || (i_mag[aomps_pkg::CAND_LEFT] < i_mag[aomps_pkg::CAND_RIGHT]));
        take_3  = i_flags.qual[aomps_pkg::CAND_TOP]
               && (!i_flags.qual[aomps_pkg::CAND_BOTTOM]
                   || (i_mag[aomps_pkg::CAND_TOP] < i_mag[aomps_pkg::CAND_BOTTOM]));
        any_lo  = i_flags.qual[aomps_pkg::CAND_RIGHT] | i_flags.qual[aomps_pkg::CAND_LEFT];
        any_hi  = i_flags.qual[aomps_pkg::CAND_BOTTOM] | i_flags.qual[aomps_pkg::CAND_TOP];
        mag_lo  = take_1 ? i_mag[aomps_pkg::CAND_LEFT] : i_mag[aomps_pkg::CAND_RIGHT];
        mag_hi  = take_3 ? i_mag[aomps_pkg::CAND_TOP] : i_mag[aomps_pkg::CAND_BOTTOM];
        take_hi = any_hi && (!any_lo || (mag_hi < mag_lo));
        win_idx = take_hi ? {1'b1, take_3} : {1'b0, take_1};
    end

    // Side code and offsets of the winner.
    always_comb begin
        n_hit      = i_flags.hit;
        n_side     = aomps_pkg::FACE_NONE;
        n_offset_x = '0;
        n_offset_y = '0;
        if (i_flags.hit && (any_lo || any_hi)) begin
            case (win_idx)
                2'(aomps_pkg::CAND_RIGHT): begin
                    n_side     = aomps_pkg::FACE_RIGHT;
                    n_offset_x = i_val[aomps_pkg::CAND_RIGHT];
                end
                2'(aomps_pkg::CAND_LEFT): begin
                    n_side     = aomps_pkg::FACE_LEFT;
                    n_offset_x = i_val[aomps_pkg::CAND_LEFT];
                end
                2'(aomps_pkg::CAND_BOTTOM): begin
                    n_side     = aomps_pkg::FACE_BOTTOM;
                    n_offset_y = i_val[aomps_pkg::CAND_BOTTOM];
                end
                default: begin
                    n_side     = aomps_pkg::FACE_TOP;
                    n_offset_y = i_val[aomps_pkg::CAND_TOP];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_side     <= n_side;
        r_offset_x <= n_offset_x;
        r_offset_y <= n_offset_y;
    end

    assign o_hit      = r_hit;
    assign o_side     = r_side;
    assign o_offset_x = r_offset_x;
    assign o_offset_y = r_offset_y;

endmodule

>>> hw/rtl/aabb_overlap_min_penetration_side.sv
// ----------------------------------------------------------------------------
// Box overlap with minimum penetration side
// Four-stage pipeline: half extents, bounds, candidates, selection.
// ----------------------------------------------------------------------------
// The block takes one box pair per clock: o_busy is always low, so an item
// is taken at every edge where i_start is high. Its result appears on the
// o_ ports after the four register stages, marked by o_valid for one cycle;
// the receiver cannot stall, and the pipeline never holds anything back.
// The register stages are the size by scale multipliers, the bound adders,
// the difference and limit compares, and the minimum select.

`include "aabb_overlap_min_penetration_side_defines.svh"

module aabb_overlap_min_penetration_side (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [aomps_pkg::POS_W-1:0]    i_a_pos_x,
    input  logic signed [aomps_pkg::POS_W-1:0]    i_a_pos_y,
    input  logic [aomps_pkg::SIZE_W-1:0]          i_a_size_x,
    input  logic [aomps_pkg::SIZE_W-1:0]          i_a_size_y,
    input  logic [aomps_pkg::SCALE_W-1:0]         i_a_scale_x,
    input  logic [aomps_pkg::SCALE_W-1:0]         i_a_scale_y,
    input  logic signed [aomps_pkg::POS_W-1:0]    i_b_pos_x,
    input  logic signed [aomps_pkg::POS_W-1:0]    i_b_pos_y,
    input  logic [aomps_pkg::SIZE_W-1:0]          i_b_size_x,
    input  logic [aomps_pkg::SIZE_W-1:0]          i_b_size_y,
    input  logic [aomps_pkg::SCALE_W-1:0]         i_b_scale_x,
    input  logic [aomps_pkg::SCALE_W-1:0]         i_b_scale_y,
    output logic                                  o_valid,
    output logic                                  o_hit,
    output logic [2:0]                            o_side,
    output logic signed [30:0]                    o_offset_x,
    output logic signed [30:0]                    o_offset_y
);

    localparam int STAGES = 4;

    logic [STAGES-1:0]                        r_vld, n_vld;
    logic signed [aomps_pkg::POS_W-1:0]       r_a_pos_x, r_a_pos_y;
    logic signed [aomps_pkg::POS_W-1:0]       r_b_pos_x, r_b_pos_y;
    logic [aomps_pkg::SIZE_W-1:0]             r_b_size_x, r_b_size_y;
    aomps_pkg::t_half                         a_half_x, a_half_y, b_half_x, b_half_y;
    aomps_pkg::t_cand_flags                   cand_flags;
    aomps_pkg::t_mag [aomps_pkg::NUM_CAND-1:0] cand_mag;
    aomps_pkg::t_val [aomps_pkg::NUM_CAND-1:0] cand_val;
    aomps_pkg::t_side                         sel_side;
    logic                                     res_miss, res_clear;
    logic                                     res_x_side, res_y_side;
    logic                                     res_right, res_left;
    logic                                     res_off_x_zero, res_off_y_zero;

    // The pipeline never stalls.
    assign o_busy = 1'b0;

    // Valid bits travel alongside the data.
    assign n_vld = {r_vld[STAGES-2:0], i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage one: centres and limits wait beside the multipliers.
    always_ff @(posedge i_clk) begin
        r_a_pos_x  <= i_a_pos_x;
        r_a_pos_y  <= i_a_pos_y;
        r_b_pos_x  <= i_b_pos_x;
        r_b_pos_y  <= i_b_pos_y;
        r_b_size_x <= i_b_size_x;
        r_b_size_y <= i_b_size_y;
    end

    aomps_half_ext u_half_ax (
        .i_clk   (i_clk),
        .i_size  (i_a_size_x),
        .i_scale (i_a_scale_x),
        .o_half  (a_half_x)
    );

    aomps_half_ext u_half_ay (
        .i_clk   (i_clk),
        .i_size  (i_a_size_y),
        .i_scale (i_a_scale_y),
        .o_half  (a_half_y)
    );

    aomps_half_ext u_half_bx (
        .i_clk   (i_clk),
        .i_size  (i_b_size_x),
        .i_scale (i_b_scale_x),
        .o_half  (b_half_x)
    );

    aomps_half_ext u_half_by (
        .i_clk   (i_clk),
        .i_size  (i_b_size_y),
        .i_scale (i_b_scale_y),
        .o_half  (b_half_y)
    );

    // Stages two and three: bounds, then candidates.
    aomps_cand u_cand (
        .i_clk      (i_clk),
        .i_a_pos_x  (r_a_pos_x),
        .i_a_pos_y  (r_a_pos_y),
        .i_a_half_x (a_half_x),
        .i_a_half_y (a_half_y),
        .i_b_pos_x  (r_b_pos_x),
        .i_b_pos_y  (r_b_pos_y),
        .i_b_half_x (b_half_x),
        .i_b_half_y (b_half_y),
        .i_b_size_x (r_b_size_x),
        .i_b_size_y (r_b_size_y),
        .o_flags    (cand_flags),
        .o_mag      (cand_mag),
        .o_val      (cand_val)
    );

    // Stage four: minimum select and result register.
    aomps_select u_select (
        .i_clk      (i_clk),
        .i_flags    (cand_flags),
        .i_mag      (cand_mag),
        .i_val      (cand_val),
        .o_hit      (o_hit),
        .o_side     (sel_side),
        .o_offset_x (o_offset_x),
        .o_offset_y (o_offset_y)
    );

    assign o_side  = sel_side;
    assign o_valid = r_vld[STAGES-1];

    // Conditions on the result item that the checks below refer to.
    assign res_off_x_zero = (o_offset_x == '0);
    assign res_off_y_zero = (o_offset_y == '0);
    assign res_miss   = o_valid && !o_hit;
    assign res_clear  = (sel_side == aomps_pkg::FACE_NONE) && res_off_x_zero && res_off_y_zero;
    assign res_right  = o_valid && (sel_side == aomps_pkg::FACE_RIGHT);
    assign res_left   = o_valid && (sel_side == aomps_pkg::FACE_LEFT);
    assign res_x_side = res_right || res_left;
    assign res_y_side = o_valid && ((sel_side == aomps_pkg::FACE_BOTTOM)
                                    || (sel_side == aomps_pkg::FACE_TOP));

    // A miss carries no side and no offsets.
    `AOMPS_ASSERT_IMPLY(a_miss_clean, i_clk, i_rst_n, res_miss, res_clear)
    // A horizontal side leaves the vertical offset at zero, and the reverse.
    `AOMPS_ASSERT_IMPLY(a_x_side_y_zero, i_clk, i_rst_n, res_x_side, res_off_y_zero)
    `AOMPS_ASSERT_IMPLY(a_y_side_x_zero, i_clk, i_rst_n, res_y_side, res_off_x_zero)
    // Right pushes back with a value at or below zero, left at or above.
    `AOMPS_ASSERT_IMPLY(a_right_sign, i_clk, i_rst_n, res_right, o_offset_x[30] || res_off_x_zero)
    `AOMPS_ASSERT_IMPLY(a_left_sign, i_clk, i_rst_n, res_left, !o_offset_x[30])

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Box overlap with minimum penetration side: testbench
// Sends box pairs through the start/busy handshake, first from a directed
// table and then at random, and checks every strobed result against the
// fixed expectation of a table row or against a predictor that computes bounds, overlap and the winning side.
// ----------------------------------------------------------------------------
module testbench;

    // One box pair as it goes onto the input ports.
    typedef struct {
        logic signed [aomps_pkg::POS_W-1:0] a_pos_x;
        logic signed [aomps_pkg::POS_W-1:0] a_pos_y;
        logic [aomps_pkg::SIZE_W-1:0]       a_size_x;
        logic [aomps_pkg::SIZE_W-1:0]       a_size_y;
        logic [aomps_pkg::SCALE_W-1:0]      a_scale_x;
        logic [aomps_pkg::SCALE_W-1:0]      a_scale_y;
        logic signed [aomps_pkg::POS_W-1:0] b_pos_x;
        logic signed [aomps_pkg::POS_W-1:0] b_pos_y;
        logic [aomps_pkg::SIZE_W-1:0]       b_size_x;
        logic [aomps_pkg::SIZE_W-1:0]       b_size_y;
        logic [aomps_pkg::SCALE_W-1:0]      b_scale_x;
        logic [aomps_pkg::SCALE_W-1:0]      b_scale_y;
    } t_box_pair;

    // One contact result.
    typedef struct {
        logic             hit;
        aomps_pkg::t_side side;
        aomps_pkg::t_val  off_x;
        aomps_pkg::t_val  off_y;
    } t_contact;

    // A row of the directed table; want is used only when fixed is set.
    typedef struct {
        t_box_pair pair;
        logic      fixed;
        t_contact  want;
    } t_stim_row;

    localparam t_contact RES_MISS        = '{1'b0, aomps_pkg::FACE_NONE, '0, '0};
    localparam t_contact RES_HIT_NO_SIDE = '{1'b1, aomps_pkg::FACE_NONE, '0, '0};

    localparam int UNIT_SCALE   = 'h1000;
    localparam int SIZE_TWO     = 'h2000;
    localparam int POS_1P5      = 'h1800;
    localparam int POS_MAX      = 'h7FFFFF;
    localparam int POS_MIN      = -'h800000;
    localparam int SIZE_MAX     = 'hFFFFFF;
    localparam int SCALE_MAX    = 'hFFFF;
    localparam int N_DIRECTED   = 20;
    localparam int N_RANDOM     = 1700;
    localparam int REPORT_LIMIT = 10;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_start;
    logic                                o_busy;
    logic signed [aomps_pkg::POS_W-1:0]  i_a_pos_x, i_a_pos_y, i_b_pos_x, i_b_pos_y;
    logic [aomps_pkg::SIZE_W-1:0]        i_a_size_x, i_a_size_y, i_b_size_x, i_b_size_y;
    logic [aomps_pkg::SCALE_W-1:0]       i_a_scale_x, i_a_scale_y, i_b_scale_x, i_b_scale_y;
    logic                                o_valid;
    logic                                o_hit;
    logic [2:0]                          o_side;
    logic signed [30:0]                  o_offset_x;
    logic signed [30:0]                  o_offset_y;

    t_contact pending_contacts [$];
    int       error_count = 0;
    int       quiet_items = 0;

    // Directed items: extremes, every side, ties, touching and degenerate boxes.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, RES_HIT_NO_SIDE},
        '{'{POS_MIN, POS_MIN, 0, 0, 0, 0, POS_MAX, POS_MAX, 0, 0, 0, 0},
          1'b1, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            POS_1P5, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            -POS_1P5, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            0, POS_1P5, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            0, -POS_1P5, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            POS_1P5, POS_1P5, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            -POS_1P5, -POS_1P5, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE},
          1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b1, RES_HIT_NO_SIDE},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            0, 0, SIZE_TWO, SIZE_TWO, 'h0800, 'h0800}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            SIZE_TWO, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            SIZE_TWO + 1, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b1, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, 0, 0,
            'h0800, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            0, 0, 0, 0, UNIT_SCALE, UNIT_SCALE}, 1'b1, RES_HIT_NO_SIDE},
        '{'{POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX,
            POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX}, 1'b0, RES_MISS},
        '{'{POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX,
            POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX}, 1'b0, RES_MISS},
        '{'{POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX, 0, 0,
            POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, 0, 0}, 1'b1, RES_MISS},
        '{'{0, 0, 'h100000, 'h100000, UNIT_SCALE, UNIT_SCALE,
            0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS},
        '{'{0, 0, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            -'h2800, 0, SIZE_TWO, SIZE_TWO, 'h2000, 'h2000}, 1'b0, RES_MISS},
        '{'{POS_MIN, POS_MAX, SIZE_TWO, SIZE_TWO, UNIT_SCALE, UNIT_SCALE,
            POS_MIN + 'h1000, POS_MAX - 'h1000, SIZE_TWO, SIZE_TWO,
            UNIT_SCALE, UNIT_SCALE}, 1'b0, RES_MISS}
    };

    aabb_overlap_min_penetration_side i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_a_pos_x   (i_a_pos_x),
        .i_a_pos_y   (i_a_pos_y),
        .i_a_size_x  (i_a_size_x),
        .i_a_size_y  (i_a_size_y),
        .i_a_scale_x (i_a_scale_x),
        .i_a_scale_y (i_a_scale_y),
        .i_b_pos_x   (i_b_pos_x),
        .i_b_pos_y   (i_b_pos_y),
        .i_b_size_x  (i_b_size_x),
        .i_b_size_y  (i_b_size_y),
        .i_b_scale_x (i_b_scale_x),
        .i_b_scale_y (i_b_scale_y),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_side      (o_side),
        .o_offset_x  (o_offset_x),
        .o_offset_y  (o_offset_y)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Half extent is size times scale, halved, back to Q.12 by truncation.
    function automatic longint half_extent(input logic [aomps_pkg::SIZE_W-1:0] size,
                                           input logic [aomps_pkg::SCALE_W-1:0] scale);
        return (longint'(size) * longint'(scale)) >>> aomps_pkg::HALF_SHIFT;
    endfunction

    // Overlap test and minimum penetration side for one box pair.
    function automatic t_contact predict_contact(input t_box_pair p);
        t_contact         c;
        longint           a_lo_x, a_hi_x, a_lo_y, a_hi_y;
        longint           b_lo_x, b_hi_x, b_lo_y, b_hi_y;
        longint           pen [aomps_pkg::NUM_CAND];
        longint           lim [aomps_pkg::NUM_CAND];
        longint           depth;
        longint           best;
        logic             sign_ok;
        aomps_pkg::t_side cand_side [aomps_pkg::NUM_CAND];
        cand_side = '{aomps_pkg::FACE_RIGHT, aomps_pkg::FACE_LEFT,
                      aomps_pkg::FACE_BOTTOM, aomps_pkg::FACE_TOP};
        c = RES_MISS;
        a_lo_x = longint'(p.a_pos_x) - half_extent(p.a_size_x, p.a_scale_x);
        a_hi_x = longint'(p.a_pos_x) + half_extent(p.a_size_x, p.a_scale_x);
        a_lo_y = longint'(p.a_pos_y) - half_extent(p.a_size_y, p.a_scale_y);
        a_hi_y = longint'(p.a_pos_y) + half_extent(p.a_size_y, p.a_scale_y);
        b_lo_x = longint'(p.b_pos_x) - half_extent(p.b_size_x, p.b_scale_x);
        b_hi_x = longint'(p.b_pos_x) + half_extent(p.b_size_x, p.b_scale_x);
        b_lo_y = longint'(p.b_pos_y) - half_extent(p.b_size_y, p.b_scale_y);
        b_hi_y = longint'(p.b_pos_y) + half_extent(p.b_size_y, p.b_scale_y);
        if (b_lo_x <= a_hi_x && b_lo_y <= a_hi_y && a_lo_x <= b_hi_x && a_lo_y <= b_hi_y) begin
            c.hit = 1'b1;
            pen[aomps_pkg::CAND_RIGHT]  = b_lo_x - a_hi_x;
            pen[aomps_pkg::CAND_LEFT]   = b_hi_x - a_lo_x;
            pen[aomps_pkg::CAND_BOTTOM] = b_lo_y - a_hi_y;
            pen[aomps_pkg::CAND_TOP]    = b_hi_y - a_lo_y;
            lim[aomps_pkg::CAND_RIGHT]  = longint'(p.b_size_x);
            lim[aomps_pkg::CAND_LEFT]   = longint'(p.b_size_x);
            lim[aomps_pkg::CAND_BOTTOM] = longint'(p.b_size_y);
            lim[aomps_pkg::CAND_TOP]    = longint'(p.b_size_y);
            best = 0;
            // Strict compare keeps the earlier candidate on equal depth.
            for (int i = 0; i < aomps_pkg::NUM_CAND; i++) begin
                depth = (pen[i] < 0) ? -pen[i] : pen[i];
                sign_ok = (i == aomps_pkg::CAND_RIGHT || i == aomps_pkg::CAND_BOTTOM)
                        ? (pen[i] <= 0) : (pen[i] >= 0);
                if (depth < lim[i] && sign_ok
                    && (c.side == aomps_pkg::FACE_NONE || depth < best)) begin
                    best   = depth;
                    c.side = cand_side[i];
                    if (i == aomps_pkg::CAND_RIGHT || i == aomps_pkg::CAND_LEFT) begin
                        c.off_x = aomps_pkg::t_val'(pen[i]);
                        c.off_y = '0;
                    end else begin
                        c.off_x = '0;
                        c.off_y = aomps_pkg::t_val'(pen[i]);
                    end
                end
            end
        end
        return c;
    endfunction

    // Random box pair. Most are small boxes near each other so that sides,
    // ties and touching edges come up often; the rest span the full fields.
    function automatic t_box_pair random_pair();
        t_box_pair p;
        int        mode;
        int        spread;
        longint    reach;
        mode = int'($urandom_range(0, 99));
        p.a_pos_x   = aomps_pkg::POS_W'($urandom());
        p.a_pos_y   = aomps_pkg::POS_W'($urandom());
        p.a_size_x  = aomps_pkg::SIZE_W'($urandom());
        p.a_size_y  = aomps_pkg::SIZE_W'($urandom());
        p.a_scale_x = aomps_pkg::SCALE_W'($urandom());
        p.a_scale_y = aomps_pkg::SCALE_W'($urandom());
        p.b_pos_x   = aomps_pkg::POS_W'($urandom());
        p.b_pos_y   = aomps_pkg::POS_W'($urandom());
        p.b_size_x  = aomps_pkg::SIZE_W'($urandom());
        p.b_size_y  = aomps_pkg::SIZE_W'($urandom());
        p.b_scale_x = aomps_pkg::SCALE_W'($urandom());
        p.b_scale_y = aomps_pkg::SCALE_W'($urandom());
        if (mode < 20) begin
            return p;
        end
        p.a_pos_x   = aomps_pkg::POS_W'(int'($urandom_range(0, 'h3FFFF)) - 'h20000);
        p.a_pos_y   = aomps_pkg::POS_W'(int'($urandom_range(0, 'h3FFFF)) - 'h20000);
        p.a_size_x  = aomps_pkg::SIZE_W'($urandom_range(0, 'h8000));
        p.a_size_y  = aomps_pkg::SIZE_W'($urandom_range(0, 'h8000));
        p.a_scale_x = aomps_pkg::SCALE_W'($urandom_range(0, 'h2000));
        p.a_scale_y = aomps_pkg::SCALE_W'($urandom_range(0, 'h2000));
        p.b_size_x  = aomps_pkg::SIZE_W'($urandom_range(0, 'h8000));
        p.b_size_y  = aomps_pkg::SIZE_W'($urandom_range(0, 'h8000));
        p.b_scale_x = aomps_pkg::SCALE_W'($urandom_range(0, 'h2000));
        p.b_scale_y = aomps_pkg::SCALE_W'($urandom_range(0, 'h2000));
        p.b_pos_x   = aomps_pkg::POS_W'(p.a_pos_x + int'($urandom_range(0, 'h10000)) - 'h8000);
        p.b_pos_y   = aomps_pkg::POS_W'(p.a_pos_y + int'($urandom_range(0, 'h10000)) - 'h8000);
        if (mode >= 55 && mode < 75) begin
            // Same square shape on both boxes and offsets of equal magnitude on both axes,
            // so that an x side and a y side tie on depth.
            p.a_size_y  = p.a_size_x;
            p.b_size_x  = p.a_size_x;
            p.b_size_y  = p.a_size_x;
            p.a_scale_y = p.a_scale_x;
            p.b_scale_x = p.a_scale_x;
            p.b_scale_y = p.a_scale_x;
            spread = int'($urandom_range(0, 'h3000));
            p.b_pos_x = aomps_pkg::POS_W'(p.a_pos_x + ($urandom_range(0, 1) ? spread : -spread));
            p.b_pos_y = aomps_pkg::POS_W'(p.a_pos_y + ($urandom_range(0, 1) ? spread : -spread));
        end else if (mode >= 75) begin
            // Edges that touch, or miss or overlap by one step.
            if ($urandom_range(0, 1)) begin
                reach = half_extent(p.a_size_x, p.a_scale_x)
                      + half_extent(p.b_size_x, p.b_scale_x)
                      + longint'($urandom_range(0, 2)) - 1;
                p.b_pos_x = aomps_pkg::POS_W'($urandom_range(0, 1) ? p.a_pos_x + reach
                                                                   : p.a_pos_x - reach);
            end else begin
                reach = half_extent(p.a_size_y, p.a_scale_y)
                      + half_extent(p.b_size_y, p.b_scale_y)
                      + longint'($urandom_range(0, 2)) - 1;
                p.b_pos_y = aomps_pkg::POS_W'($urandom_range(0, 1) ? p.a_pos_y + reach
                                                                   : p.a_pos_y - reach);
            end
        end
        return p;
    endfunction

    // Put a pair on the input ports.
    task automatic put_pair(input t_box_pair p);
        i_a_pos_x   <= p.a_pos_x;
        i_a_pos_y   <= p.a_pos_y;
        i_a_size_x  <= p.a_size_x;
        i_a_size_y  <= p.a_size_y;
        i_a_scale_x <= p.a_scale_x;
        i_a_scale_y <= p.a_scale_y;
        i_b_pos_x   <= p.b_pos_x;
        i_b_pos_y   <= p.b_pos_y;
        i_b_size_x  <= p.b_size_x;
        i_b_size_y  <= p.b_size_y;
        i_b_scale_x <= p.b_scale_x;
        i_b_scale_y <= p.b_scale_y;
    endtask

    // Offer one item and wait for the edge that takes it.
    task automatic send_pair(input t_box_pair p, input t_contact want);
        i_start <= 1'b1;
        put_pair(p);
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_contacts = {pending_contacts, want};
    endtask

    // Random gap after an item: mostly none, some short, a few long, and
    // now and then a run of items back to back. Garbage sits on the data
    // ports while start is low.
    task automatic pause_between_items();
        int gap;
        int roll;
        gap  = 0;
        roll = int'($urandom_range(0, 99));
        if (quiet_items > 0) begin
            quiet_items--;
        end else if (roll < 3) begin
            quiet_items = int'($urandom_range(20, 60));
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = int'($urandom_range(1, 3));
        end else begin
            gap = int'($urandom_range(4, 40));
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            put_pair(random_pair());
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result checker: every strobe is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_contacts.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no item pending: hit=%0d side=%0d x=%0d y=%0d",
                             $time, o_hit, o_side, o_offset_x, o_offset_y);
                end
            end else begin
                want = pending_contacts.pop_front();
                if (o_valid !== 1'b1 || o_hit !== want.hit || o_side !== want.side ||
                    o_offset_x !== want.off_x || o_offset_y !== want.off_y) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: expected hit=%0d side=%0d x=%0d y=%0d",
                                 $time, want.hit, want.side, want.off_x, want.off_y);
                        $display("%0t:           got      hit=%0d side=%0d x=%0d y=%0d",
                                 $time, o_hit, o_side, o_offset_x, o_offset_y);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, random items, drain.
    initial begin
        t_box_pair p;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        put_pair(directed_rows[0].pair);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_pair(directed_rows[k].pair,
                      directed_rows[k].fixed ? directed_rows[k].want
                                             : predict_contact(directed_rows[k].pair));
            pause_between_items();
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            p = random_pair();
            send_pair(p, predict_contact(p));
            pause_between_items();
        end

        // Drain, then keep watching for any stray strobe before the verdict.
        i_start <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
